// ===== hdl/chte_pkg.sv =====
// Package for the chained hash table engine: payload structs, opcodes,
// status codes, controller states and the controller/datapath command struct.
// No dependencies.
package chte_pkg;

  localparam logic [63:0] HASH_MULT = 64'h0000_0000_045d_9f3b;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [63:0] key;
    logic [63:0]        value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [63:0] read_value;
    logic [8:0]  buckets_in_use;
    logic [11:0] entry_total;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1_LO,
    S_MUL1_HI,
    S_MUL2_LO,
    S_MUL2_HI,
    S_MOD,
    S_FILL,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_COMMIT,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic mod_start;
    logic fill_rd;
    logic scan_rd;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic commit_ins;
    logic commit_rem;
    logic result_miss;
    logic result_full;
    logic result_ok;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic    mod_done;
    logic    bucket_full;
    logic    bucket_empty;
    logic    key_match;
    logic    scan_last;
    logic    shift_last;
    opcode_t op;
  } dp_stat_t;

endpackage

// ===== hdl/chte_mod_unit.sv =====
// Iterative modulo unit: 64-bit unsigned dividend by a 9-bit divisor,
// restoring division, one quotient bit per cycle. Uses chte_pkg nothing.
module chte_mod_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic [8:0]  remainder
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [9:0]  rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [9:0]  trial;

  assign trial = {rem_r[8:0], dvd_r[63]};

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[62:0], 1'b0};
      rem_nxt = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[8:0];

endmodule

// ===== hdl/chte_datapath.sv =====
// Datapath of the hash table engine: hash registers, modulo unit, slot
// memories, fill table and counters. Depends on chte_pkg and chte_mod_unit.
module chte_datapath import chte_pkg::*; #(
  parameter int MAX_BUCKETS      = 256,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic [8:0] bucket_count,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_item
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FW = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int AW = BW + SW;
  localparam int DEPTH = MAX_BUCKETS << SW;

  logic [63:0] slot_key_mem [DEPTH];
  logic [63:0] slot_val_mem [DEPTH];
  logic [FW-1:0] fill_mem [MAX_BUCKETS];

  logic [1:0]    op_r;
  logic [63:0]   key_r, val_r, hash_r, hash_nxt;
  logic [63:0]   prod_lo_r;
  logic [31:0]   prod_hi_r;
  logic [BW-1:0] bucket_r;
  logic [FW-1:0] fill_r;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [63:0]   rd_key_r, rd_val_r;
  logic [1:0]    status_r;
  logic          found_r;
  logic [63:0]   read_value_r;
  logic [8:0]    used_r;
  logic [11:0]   total_r;
  logic [FW-1:0] fill_clr_r;
  logic          fill_valid_r [MAX_BUCKETS];

  logic [63:0] mix;
  logic [63:0] prod_lo;
  logic [31:0] prod_hi;
  logic [16:0] n_eff;
  logic [8:0]  divisor;
  logic        mod_done;
  logic [8:0]  rem;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0] wr_key, wr_val;
  logic        wr_en;

  function automatic logic [63:0] sar32(input logic [63:0] x);
    sar32 = {{32{x[63]}}, x[63:32]};
  endfunction

  assign mix = sar32(hash_r) ^ hash_r;

  // The multiplier fits in 32 bits, so the 64-bit product is built from two
  // 32 x 32 partial products; only the low half of the upper one is needed.
  assign prod_lo = mix[31:0] * HASH_MULT[31:0];
  assign prod_hi = mix[63:32] * HASH_MULT[31:0];

  // Saturate bucket count to the range 1..MAX_BUCKETS.
  always_comb begin
    n_eff = {8'd0, bucket_count};
    if (bucket_count == 9'd0) n_eff = 17'd1;
    if (n_eff > 17'(MAX_BUCKETS)) n_eff = 17'(MAX_BUCKETS);
    divisor = n_eff[8:0];
  end

  chte_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mod_start),
    .dividend  (mix),
    .divisor   (divisor),
    .done      (mod_done),
    .remainder (rem)
  );

  always_comb begin
    hash_nxt = hash_r;
    if (cmd.load) hash_nxt = in_item.key;
    else if (cmd.mul_hi) hash_nxt = prod_lo_r + {prod_hi_r, 32'd0};
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.fill_rd) idx_nxt = '0;
    else if (cmd.scan_rd && !stat.key_match && stat.op != OP_INSERT) idx_nxt = idx_r + SW'(1);
    else if (cmd.shift_wr) idx_nxt = idx_r + SW'(1);
  end

  // Reads address the current slot, or the next one during a shift.
  assign rd_addr = cmd.shift_rd ? {bucket_r, idx_r + SW'(1)} : {bucket_r, idx_r};
  always_comb begin
    wr_en   = cmd.shift_wr || cmd.ins_wr;
    wr_addr = cmd.ins_wr ? {bucket_r, fill_r[SW-1:0]} : {bucket_r, idx_r};
    wr_key  = cmd.ins_wr ? key_r : rd_key_r;
    wr_val  = cmd.ins_wr ? val_r : rd_val_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_key_mem[wr_addr] <= wr_key;
      slot_val_mem[wr_addr] <= wr_val;
    end
    rd_key_r <= slot_key_mem[rd_addr];
    rd_val_r <= slot_val_mem[rd_addr];
  end

  // Fill table with per-bucket valid bits; an invalid entry reads as zero.
  always_ff @(posedge clk) begin
    if (cmd.commit_ins) fill_mem[bucket_r] <= fill_r + FW'(1);
    else if (cmd.commit_rem) fill_mem[bucket_r] <= fill_r - FW'(1);
    fill_clr_r <= fill_mem[bucket_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < MAX_BUCKETS; b++) fill_valid_r[b] <= 1'b0;
    end else if (cmd.commit_ins || cmd.commit_rem) begin
      fill_valid_r[bucket_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      total_r <= '0;
    end else begin
      if (cmd.commit_ins) begin
        total_r <= total_r + 12'd1;
        if (fill_r == '0) used_r <= used_r + 9'd1;
      end else if (cmd.commit_rem) begin
        total_r <= total_r - 12'd1;
        if (fill_r == FW'(1)) used_r <= used_r - 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    idx_r  <= idx_nxt;
    if (cmd.mul_lo) begin
      prod_lo_r <= prod_lo;
      prod_hi_r <= prod_hi;
    end
    if (cmd.load) begin
      op_r  <= in_item.opcode;
      key_r <= in_item.key;
      val_r <= in_item.value;
      status_r     <= ST_OK;
      found_r      <= 1'b0;
      read_value_r <= '0;
    end
    if (mod_done) bucket_r <= BW'(rem);
    if (cmd.scan_rd && stat.key_match) begin
      found_r <= 1'b1;
      if (op_r == OP_LOOKUP) read_value_r <= rd_val_r;
    end
    if (cmd.result_miss) status_r <= ST_NOT_FOUND;
    if (cmd.result_full) status_r <= ST_FULL;
    if (cmd.result_ok)   status_r <= ST_OK;
  end

  // Fill register: latched in the cycle after the table read.
  logic fill_rd_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) fill_rd_d_r <= 1'b0;
    else        fill_rd_d_r <= cmd.fill_rd;
    if (fill_rd_d_r)
      fill_r <= fill_valid_r[bucket_r] ? fill_clr_r : '0;
  end

  always_comb begin
    stat.mod_done     = mod_done;
    stat.bucket_full  = (fill_r >= FW'(SLOTS_PER_BUCKET));
    stat.bucket_empty = (fill_r == '0);
    stat.key_match    = (rd_key_r == key_r);
    stat.scan_last    = ((FW+1)'(idx_r) + (FW+1)'(1) >= (FW+1)'(fill_r));
    stat.shift_last   = ((FW+1)'(idx_r) + (FW+1)'(2) >= (FW+1)'(fill_r));
    stat.op           = opcode_t'(op_r);
  end

  always_comb begin
    out_item.status         = status_r;
    out_item.found          = found_r;
    out_item.read_value     = read_value_r;
    out_item.buckets_in_use = used_r;
    out_item.entry_total    = total_r;
  end

endmodule

// ===== hdl/chte_ctrl.sv =====
// Controller state machine of the hash table engine: sequences hashing,
// bucket scan, slot shift and commit. Depends on chte_pkg.
module chte_ctrl import chte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   fill_wait_r, fill_wait_nxt;
  logic   mod_started_r;

  always_comb begin
    state_nxt     = state_r;
    fill_wait_nxt = 1'b0;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_MUL1_LO;
      S_MUL1_LO:  state_nxt = S_MUL1_HI;
      S_MUL1_HI:  state_nxt = S_MUL2_LO;
      S_MUL2_LO:  state_nxt = S_MUL2_HI;
      S_MUL2_HI:  state_nxt = S_MOD;
      S_MOD:      if (stat.mod_done) state_nxt = S_FILL;
      S_FILL: begin
        // Table read, then the fill register takes its value.
        fill_wait_nxt = !fill_wait_r;
        if (fill_wait_r) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.op == OP_INSERT) state_nxt = S_COMMIT;
        else if (stat.op == OP_NOP || stat.bucket_empty) state_nxt = S_OUT;
        else state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD:  state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (stat.key_match) begin
          if (stat.op == OP_REMOVE)
            state_nxt = stat.scan_last ? S_COMMIT : S_SHIFT_RD;
          else
            state_nxt = S_OUT;
        end else if (stat.scan_last) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = stat.shift_last ? S_COMMIT : S_SHIFT_RD;
      S_COMMIT:   state_nxt = S_OUT;
      S_OUT:      if (out_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_MUL1_LO:  cmd.mul_lo = 1'b1;
      S_MUL1_HI:  cmd.mul_hi = 1'b1;
      S_MUL2_LO:  cmd.mul_lo = 1'b1;
      S_MUL2_HI:  cmd.mul_hi = 1'b1;
      // The modulo unit starts in the first cycle here, once the hash has settled.
      S_MOD:      cmd.mod_start = !mod_started_r;
      S_FILL:     cmd.fill_rd = !fill_wait_r;
      S_DISPATCH: begin
        if (stat.op != OP_INSERT && stat.op != OP_NOP && stat.bucket_empty)
          cmd.result_miss = 1'b1;
      end
      S_SCAN_RD:  cmd.scan_rd = 1'b0;
      S_SCAN_CMP: begin
        cmd.scan_rd = 1'b1;
        if (!stat.key_match && stat.scan_last) cmd.result_miss = 1'b1;
      end
      S_SHIFT_RD: cmd.shift_rd = 1'b1;
      S_SHIFT_WR: cmd.shift_wr = 1'b1;
      S_COMMIT: begin
        if (stat.op == OP_INSERT) begin
          if (stat.bucket_full) cmd.result_full = 1'b1;
          else begin
            cmd.ins_wr     = 1'b1;
            cmd.commit_ins = 1'b1;
          end
        end else begin
          cmd.commit_rem = 1'b1;
        end
      end
      S_OUT:      out_valid = 1'b1;
      default:    cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fill_wait_r   <= 1'b0;
      mod_started_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fill_wait_r   <= fill_wait_nxt;
      mod_started_r <= (state_r == S_MOD);
    end
  end

endmodule

// ===== hdl/chained_hash_table_engine_core.sv =====
// Chained hash table engine: insert, remove and lookup on signed 64-bit keys.
// An insert and a no-op skip the scan, as does a lookup or remove on an empty bucket;
// a lookup or a remove scans the bucket slot by slot, and a remove that hits then
// shifts the later slots down. The modulo unit's 64 steps dominate the latency.
// One request at a time: the next input beat is taken the cycle after the result
// beat. Synchronous active-low reset clears control state, counters and the per-bucket
// fill valid bits, so no clearing pass is needed; bucket count 256.
module chained_hash_table_engine_core import chte_pkg::*; #(
  parameter int MAX_BUCKETS      = 256,
  parameter int SLOTS_PER_BUCKET = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_bucket_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [8:0] bucket_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= 9'd256;
    else if (cfg_valid) bucket_count_r <= cfg_bucket_count;
  end

  chte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  chte_datapath #(
    .MAX_BUCKETS      (MAX_BUCKETS),
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_item      (in_data),
    .bucket_count (bucket_count_r),
    .cmd          (cmd),
    .stat         (stat),
    .out_item     (out_data)
  );

endmodule
